### hdl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types and constants of the framed FIR with edge pass-through.
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int TAP_BITS   = 18;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_BITS   = 5;
  localparam int INDEX_BITS = 6;
  localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    PTR_OLDEST = 2'd0,
    PTR_MID    = 2'd1,
    PTR_FLUSH  = 2'd2
  } ptr_sel_t;

  typedef enum logic {
    OUT_SUM  = 1'b0,
    OUT_HIST = 1'b1
  } out_src_t;

  typedef struct packed {
    logic     ready;
    logic     take;
    logic     ptr_load;
    ptr_sel_t ptr_sel;
    logic     hist_step;
    logic     tap_clear;
    logic     mac_issue;
    logic     acc_clear;
    logic     flush_dec;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } fce_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic frame_end;
    logic sample_pass;
    logic sample_mac;
    logic sample_flush;
    logic tap_last;
    logic flush_last;
    logic mac_busy;
    logic out_free;
  } fce_status_t;

endpackage

### hdl/fce_in_if.sv
// ----------------------------------------------------------------------------
// fce_in_if
// Input channel: data samples and coefficient loads with valid/ready.
// ----------------------------------------------------------------------------
interface fce_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [SAMPLE_BITS-1:0]          sample_value;
  logic                                   frame_end;
  logic [fce_pkg::INDEX_BITS-1:0]         tap_index;
  logic signed [fce_pkg::TAP_BITS-1:0]    tap_value;

  modport source (
    output valid, mode, sample_value, frame_end, tap_index, tap_value,
    input  ready
  );

  modport sink (
    input  valid, mode, sample_value, frame_end, tap_index, tap_value,
    output ready
  );
endinterface

### hdl/fce_out_if.sv
// ----------------------------------------------------------------------------
// fce_out_if
// Output channel: filtered samples with frame marker and clip flag.
// ----------------------------------------------------------------------------
interface fce_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_sample;
  logic                          last_of_frame;
  logic                          clipped;

  modport source (
    output valid, filtered_sample, last_of_frame, clipped,
    input  ready
  );

  modport sink (
    input  valid, filtered_sample, last_of_frame, clipped,
    output ready
  );
endinterface

### hdl/fce_ram.sv
// ----------------------------------------------------------------------------
// fce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fce_ctrl.sv
// ----------------------------------------------------------------------------
// fce_ctrl
// Sequencer: accepts one transaction, then steps the datapath through the
// multiply-accumulate, pass-through and frame-end flush phases.
// ----------------------------------------------------------------------------
module fce_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  fce_pkg::fce_status_t st,
  output fce_pkg::fce_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_MAC_LOAD   = 11'b000_0000_0010,
    S_MAC_RUN    = 11'b000_0000_0100,
    S_MAC_WAIT   = 11'b000_0000_1000,
    S_MAC_EMIT   = 11'b000_0001_0000,
    S_PASS_LOAD  = 11'b000_0010_0000,
    S_PASS_RD    = 11'b000_0100_0000,
    S_PASS_EMIT  = 11'b000_1000_0000,
    S_FLUSH_LOAD = 11'b001_0000_0000,
    S_FLUSH_RD   = 11'b010_0000_0000,
    S_FLUSH_EMIT = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fe_q;
  logic   fl_q;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (st.in_valid) begin
          cmd.take = 1'b1;
          if (st.in_mode != fce_pkg::MODE_LOAD) begin
            if (st.sample_pass) begin
              state_next = S_PASS_LOAD;
            end else if (st.sample_mac) begin
              state_next = S_MAC_LOAD;
            end else if (st.sample_flush) begin
              state_next = S_FLUSH_LOAD;
            end
          end
        end
      end
      S_MAC_LOAD: begin
        cmd.ptr_load  = 1'b1;
        cmd.ptr_sel   = fce_pkg::PTR_OLDEST;
        cmd.tap_clear = 1'b1;
        cmd.acc_clear = 1'b1;
        state_next    = S_MAC_RUN;
      end
      S_MAC_RUN: begin
        cmd.mac_issue = 1'b1;
        if (st.tap_last) begin
          state_next = S_MAC_WAIT;
        end
      end
      S_MAC_WAIT: begin
        if (!st.mac_busy) begin
          state_next = S_MAC_EMIT;
        end
      end
      S_MAC_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = fce_pkg::OUT_SUM;
          cmd.out_last = fe_q && !fl_q;
          state_next   = fl_q ? S_FLUSH_LOAD : S_IDLE;
        end
      end
      S_PASS_LOAD: begin
        cmd.ptr_load = 1'b1;
        cmd.ptr_sel  = fce_pkg::PTR_MID;
        state_next   = S_PASS_RD;
      end
      S_PASS_RD: begin
        state_next = S_PASS_EMIT;
      end
      S_PASS_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = fce_pkg::OUT_HIST;
          cmd.out_last = fe_q && !fl_q;
          state_next   = fl_q ? S_FLUSH_LOAD : S_IDLE;
        end
      end
      S_FLUSH_LOAD: begin
        cmd.ptr_load = 1'b1;
        cmd.ptr_sel  = fce_pkg::PTR_FLUSH;
        state_next   = S_FLUSH_RD;
      end
      S_FLUSH_RD: begin
        state_next = S_FLUSH_EMIT;
      end
      S_FLUSH_EMIT: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_src   = fce_pkg::OUT_HIST;
          cmd.out_last  = st.flush_last;
          cmd.hist_step = 1'b1;
          cmd.flush_dec = 1'b1;
          state_next    = st.flush_last ? S_IDLE : S_FLUSH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fe_q  <= 1'b0;
      fl_q  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take && st.in_mode != fce_pkg::MODE_LOAD) begin
        fe_q <= st.frame_end;
        fl_q <= st.sample_flush;
      end
    end
  end

  a_sum_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC_EMIT) |-> !st.mac_busy)
    else $error("sum emitted while products still in flight");

  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_EMIT) |-> fl_q)
    else $error("flush running without a pending frame end");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == S_IDLE))
    else $error("frame marker sent before the item finished");

endmodule

### hdl/fce_datapath.sv
// ----------------------------------------------------------------------------
// fce_datapath
// Tap store, sample history, shared multiply-accumulate, rounding and
// saturation, frame position tracking and the output register.
// ----------------------------------------------------------------------------
module fce_datapath #(
  parameter int HALF_MAX    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fce_pkg::CFG_BITS-1:0]    cfg_wdata,
  fce_in_if.sink                          item,
  fce_out_if.source                       result,
  input  fce_pkg::fce_cmd_t               cmd,
  output fce_pkg::fce_status_t            st
);

  localparam int DEPTH = 2 * HALF_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(HALF_MAX + 1);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int TB    = fce_pkg::TAP_BITS;
  localparam int PW    = SAMPLE_BITS + TB;
  localparam int ACCW  = PW + $clog2(DEPTH);
  localparam int RW    = ACCW - fce_pkg::FRAC_BITS;

  logic [fce_pkg::CFG_BITS-1:0]  half_width;
  logic [HW-1:0]                 h;
  logic [AW-1:0]                 two_h;
  logic [CW-1:0]                 taps;
  logic [CW-1:0]                 seen_count;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 cnt_next;
  logic [HW-1:0]                 rem;
  logic [HW-1:0]                 flush_left;
  logic [AW-1:0]                 flush_d;
  logic [AW-1:0]                 wp;
  logic [AW-1:0]                 hp;
  logic [AW-1:0]                 tp;
  logic [AW-1:0]                 back_dist;
  logic [AW:0]                   back_sum;
  logic [AW:0]                   back_wrap;
  logic [AW-1:0]                 hp_start;
  logic [DEPTH-1:0]              hist_valid;
  logic                          hist_vld_q;
  logic signed [SAMPLE_BITS-1:0] hist_rdata;
  logic signed [SAMPLE_BITS-1:0] hist_sample;
  logic signed [TB-1:0]          tap_rdata;
  logic                          iss_d1;
  logic                          prod_vld;
  logic signed [PW-1:0]          prod;
  logic signed [ACCW-1:0]        acc;
  logic signed [ACCW-1:0]        acc_rnd;
  logic signed [RW-1:0]          rsum;
  logic [RW-SAMPLE_BITS:0]       rsum_top;
  logic [SAMPLE_BITS-1:0]        sat_val;
  logic                          sat_clip;
  logic                          take_sample;
  logic                          take_load;
  logic                          tap_we;
  logic                          out_valid;
  logic [SAMPLE_BITS-1:0]        out_value;
  logic                          out_last;
  logic                          out_clip;

  // frame position bookkeeping
  always_comb begin
    if (int'(half_width) > HALF_MAX) begin
      h = HW'(HALF_MAX);
    end else begin
      h = HW'(half_width);
    end
    two_h    = AW'(h) << 1;
    taps     = CW'(two_h) + CW'(1);
    cnt      = (seen_count > taps) ? taps : seen_count;
    cnt_next = (cnt == taps) ? taps : cnt + CW'(1);
    rem      = (cnt_next > CW'(h)) ? h : HW'(cnt_next);
  end

  assign take_sample = cmd.take && (item.mode != fce_pkg::MODE_LOAD);
  assign take_load   = cmd.take && (item.mode == fce_pkg::MODE_LOAD);
  assign tap_we      = take_load && (int'(item.tap_index) < DEPTH);

  // history read start: d samples back from the newest
  always_comb begin
    unique case (cmd.ptr_sel)
      fce_pkg::PTR_OLDEST: back_dist = two_h;
      fce_pkg::PTR_MID:    back_dist = AW'(h);
      fce_pkg::PTR_FLUSH:  back_dist = flush_d;
      default:             back_dist = two_h;
    endcase
    back_sum  = {1'b0, wp} + ((AW + 1)'(DEPTH - 1) - {1'b0, back_dist});
    back_wrap = back_sum - (AW + 1)'(DEPTH);
    hp_start  = (back_sum >= (AW + 1)'(DEPTH)) ? back_wrap[AW-1:0] : back_sum[AW-1:0];
  end

  fce_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (take_sample),
    .waddr (wp),
    .wdata (item.sample_value),
    .raddr (hp),
    .rdata (hist_rdata)
  );

  fce_ram #(
    .WIDTH (TB),
    .DEPTH (DEPTH)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (AW'(item.tap_index)),
    .wdata (item.tap_value),
    .raddr (tp),
    .rdata (tap_rdata)
  );

  assign hist_sample = hist_vld_q ? hist_rdata : '0;

  // round half up, then saturate
  always_comb begin
    acc_rnd  = acc + ACCW'(fce_pkg::ROUND_HALF);
    rsum     = RW'(acc_rnd >>> fce_pkg::FRAC_BITS);
    rsum_top = rsum[RW-1:SAMPLE_BITS-1];
    if ((&rsum_top) || !(|rsum_top)) begin
      sat_val  = rsum[SAMPLE_BITS-1:0];
      sat_clip = 1'b0;
    end else if (rsum[RW-1]) begin
      sat_val  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      sat_clip = 1'b1;
    end else begin
      sat_val  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      sat_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
      seen_count <= '0;
      wp         <= '0;
      hp         <= '0;
      tp         <= '0;
      hist_valid <= '0;
      flush_left <= '0;
      iss_d1     <= 1'b0;
      prod_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_width <= cfg_wdata;
      end
      if (take_sample) begin
        seen_count     <= item.frame_end ? '0 : cnt_next;
        wp             <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
        hist_valid[wp] <= 1'b1;
        flush_left     <= rem;
      end else if (cmd.flush_dec) begin
        flush_left <= flush_left - HW'(1);
      end
      if (cmd.ptr_load) begin
        hp <= hp_start;
      end else if (cmd.mac_issue || cmd.hist_step) begin
        hp <= (hp == AW'(DEPTH - 1)) ? '0 : hp + AW'(1);
      end
      if (cmd.tap_clear) begin
        tp <= '0;
      end else if (cmd.mac_issue && !st.tap_last) begin
        tp <= tp + AW'(1);
      end
      iss_d1   <= cmd.mac_issue;
      prod_vld <= iss_d1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      flush_d <= AW'(rem) - AW'(1);
    end
    hist_vld_q <= hist_valid[hp];
    if (iss_d1) begin
      prod <= PW'(hist_sample) * PW'(tap_rdata);
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACCW'(prod);
    end
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      if (cmd.out_src == fce_pkg::OUT_SUM) begin
        out_value <= sat_val;
        out_clip  <= sat_clip;
      end else begin
        out_value <= hist_sample;
        out_clip  <= 1'b0;
      end
    end
  end

  assign item.ready             = cmd.ready;
  assign result.valid           = out_valid;
  assign result.filtered_sample = out_value;
  assign result.last_of_frame   = out_last;
  assign result.clipped         = out_clip;

  always_comb begin
    st.in_valid     = item.valid;
    st.in_mode      = item.mode;
    st.frame_end    = item.frame_end;
    st.sample_pass  = (cnt >= CW'(h)) && (cnt < CW'(two_h));
    st.sample_mac   = (cnt >= CW'(two_h));
    st.sample_flush = item.frame_end && (rem != '0);
    st.tap_last     = (tp == two_h);
    st.flush_last   = (flush_left == HW'(1));
    st.mac_busy     = iss_d1 || prod_vld;
    st.out_free     = !out_valid || result.ready;
  end

  a_take_when_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !(iss_d1 || prod_vld))
    else $error("transaction accepted with products in flight");

  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_dec |-> (flush_left != '0))
    else $error("flush step with no position left");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || result.ready))
    else $error("output register overwritten before it was taken");

endmodule

### hdl/fir_convolve_edge_passthrough.sv
// ----------------------------------------------------------------------------
// fir_convolve_edge_passthrough
// Framed odd-length FIR with rounded, saturated sums and edge pass-through.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A coefficient load, and a sample that
// completes no frame position, is accepted and finished in the idle state. A
// sample that releases an edge position of its frame reads that position back
// from the history RAM; a sample at an interior position runs the single shared
// multiply-accumulate that walks the 2*H+1 taps one per cycle through the tap
// and history RAM read ports, followed by the read and product pipeline drain.
// A frame-end sample then flushes each remaining position from the history.
// Output stalls hold the sequencer; the output register lets the next
// transaction in while the last result waits.
module fir_convolve_edge_passthrough #(
  parameter int HALF_MAX    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [fce_pkg::CFG_BITS-1:0] cfg_wdata,
  fce_in_if.sink                       item,
  fce_out_if.source                    result
);

  fce_pkg::fce_cmd_t    cmd;
  fce_pkg::fce_status_t st;

  fce_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  fce_datapath #(
    .HALF_MAX    (HALF_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

### tb/tb_fir_convolve_edge_passthrough.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_convolve_edge_passthrough
// Self-checking bench for the framed FIR with edge pass-through. Coefficient
// and sample transactions go in through the input channel. A built-in
// predictor tracks the tap store, the sample history and the frame position,
// and checks every output transaction field by field. Random phases change
// the half width, the frame shapes and the idle/stall pressure on both sides.
// ----------------------------------------------------------------------------
module tb_fir_convolve_edge_passthrough;

  localparam int HALF_MAX       = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int DEPTH          = 2 * HALF_MAX + 1;
  localparam int LATENCY_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 400;
  localparam longint SAT_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN    = -SAT_MAX - 1;

  typedef struct {
    logic                                mode;
    logic signed [SAMPLE_BITS-1:0]       sample_value;
    logic                                frame_end;
    logic [fce_pkg::INDEX_BITS-1:0]      tap_index;
    logic signed [fce_pkg::TAP_BITS-1:0] tap_value;
  } fir_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] filtered_sample;
    logic                          last_of_frame;
    logic                          clipped;
  } fir_output_t;

  class fir_frame_scoreboard;
    logic signed [fce_pkg::TAP_BITS-1:0] tap_mem[DEPTH];
    logic signed [SAMPLE_BITS-1:0]       history[DEPTH];
    int unsigned                         wr_ptr;
    int unsigned                         seen;
    logic [fce_pkg::CFG_BITS-1:0]        half_width;
    fir_output_t                         expected_outputs[$];
    int                                  errors;

    function new();
      foreach (tap_mem[k]) tap_mem[k] = '0;
      foreach (history[k]) history[k] = '0;
      wr_ptr = 0;
      seen = 0;
      half_width = '0;
      errors = 0;
    endfunction

    function void set_half_width(logic [fce_pkg::CFG_BITS-1:0] value);
      half_width = value;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // d = 0 is the newest sample
    function logic signed [SAMPLE_BITS-1:0] hist_back(int unsigned d);
      return history[(wr_ptr + DEPTH - 1 - d) % DEPTH];
    endfunction

    function void push_output(logic signed [SAMPLE_BITS-1:0] value, logic clip);
      fir_output_t o;
      o.filtered_sample = value;
      o.last_of_frame = 1'b0;
      o.clipped = clip;
      expected_outputs.push_back(o);
    endfunction

    function void accept_item(fir_item_t it);
      int unsigned h;
      int unsigned taps;
      int unsigned cnt;
      int unsigned pos;
      int unsigned rem;
      int          size_before;
      longint      acc;
      longint      rounded;
      logic        clip;
      h = (half_width > HALF_MAX) ? HALF_MAX : half_width;
      taps = 2 * h + 1;
      if (it.mode == fce_pkg::MODE_LOAD) begin
        if (it.tap_index < DEPTH) tap_mem[it.tap_index] = it.tap_value;
        return;
      end
      cnt = (seen > taps) ? taps : seen;
      pos = cnt;
      history[wr_ptr] = it.sample_value;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      cnt = (cnt + 1 > taps) ? taps : cnt + 1;
      seen = cnt;
      size_before = expected_outputs.size();
      if (pos >= h) begin
        if (pos < 2 * h) begin
          push_output(hist_back(h), 1'b0);
        end else begin
          acc = 0;
          for (int unsigned j = 0; j < taps; j++)
            acc += longint'(tap_mem[j]) * longint'(hist_back(2 * h - j));
          rounded = (acc + fce_pkg::ROUND_HALF) >>> fce_pkg::FRAC_BITS;
          clip = 1'b0;
          if (rounded > SAT_MAX) begin
            rounded = SAT_MAX;
            clip = 1'b1;
          end
          if (rounded < SAT_MIN) begin
            rounded = SAT_MIN;
            clip = 1'b1;
          end
          push_output(rounded[SAMPLE_BITS-1:0], clip);
        end
      end
      if (it.frame_end) begin
        rem = (cnt > h) ? h : cnt;
        for (int unsigned i = 0; i < rem; i++) push_output(hist_back(rem - 1 - i), 1'b0);
        if (expected_outputs.size() > size_before)
          expected_outputs[expected_outputs.size() - 1].last_of_frame = 1'b1;
        seen = 0;
      end
    endfunction

    function void check_result(fir_output_t got);
      fir_output_t exp_out;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output transaction: filtered_sample %0d", got.filtered_sample);
        errors++;
        return;
      end
      exp_out = expected_outputs.pop_front();
      if (got.filtered_sample !== exp_out.filtered_sample) begin
        $error("filtered_sample: expected %0d, actual %0d",
               exp_out.filtered_sample, got.filtered_sample);
        errors++;
      end
      if (got.last_of_frame !== exp_out.last_of_frame) begin
        $error("last_of_frame: expected %0b, actual %0b",
               exp_out.last_of_frame, got.last_of_frame);
        errors++;
      end
      if (got.clipped !== exp_out.clipped) begin
        $error("clipped: expected %0b, actual %0b", exp_out.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [fce_pkg::CFG_BITS-1:0] cfg_wdata;

  fce_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) item_if ();
  fce_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

  fir_convolve_edge_passthrough #(
    .HALF_MAX    (HALF_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  fir_frame_scoreboard sb;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // output side: check accepted transactions, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        fir_output_t got;
        got.filtered_sample = result_if.filtered_sample;
        got.last_of_frame = result_if.last_of_frame;
        got.clipped = result_if.clipped;
        sb.check_result(got);
      end
      result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'(SAT_MAX);
      1:       return SAMPLE_BITS'(SAT_MIN);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [fce_pkg::TAP_BITS-1:0] rand_tap();
    case ($urandom_range(0, 3))
      0:       return fce_pkg::TAP_BITS'($urandom);
      1:       return fce_pkg::TAP_BITS'(($urandom_range(0, 1) ? 65536 : -65536)
                                         + int'($urandom_range(0, 255)) - 128);
      default: return fce_pkg::TAP_BITS'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic drive_item(fir_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.mode         <= it.mode;
    item_if.sample_value <= it.sample_value;
    item_if.frame_end    <= it.frame_end;
    item_if.tap_index    <= it.tap_index;
    item_if.tap_value    <= it.tap_value;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    sb.accept_item(it);
  endtask

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, logic last);
    fir_item_t it;
    it.mode = fce_pkg::MODE_SAMPLE;
    it.sample_value = value;
    it.frame_end = last;
    it.tap_index = fce_pkg::INDEX_BITS'($urandom);
    it.tap_value = fce_pkg::TAP_BITS'($urandom);
    drive_item(it);
  endtask

  task automatic send_load(logic [fce_pkg::INDEX_BITS-1:0] idx,
                           logic signed [fce_pkg::TAP_BITS-1:0] value, logic last);
    fir_item_t it;
    it.mode = fce_pkg::MODE_LOAD;
    it.sample_value = SAMPLE_BITS'($urandom);
    it.frame_end = last;
    it.tap_index = idx;
    it.tap_value = value;
    drive_item(it);
  endtask

  // pause the sender until every expected output has come
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_half_width(logic [fce_pkg::CFG_BITS-1:0] value);
    wait_drained();
    repeat (LATENCY_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_half_width(value);
  endtask

  initial begin
    int                           sent;
    int                           phase;
    int                           budget;
    int                           frame_len;
    int unsigned                  heff;
    logic [fce_pkg::CFG_BITS-1:0] hw;
    bit                           paused;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    item_if.valid        <= 1'b0;
    item_if.mode         <= fce_pkg::MODE_SAMPLE;
    item_if.sample_value <= '0;
    item_if.frame_end    <= 1'b0;
    item_if.tap_index    <= '0;
    item_if.tap_value    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole tap store before any sum is formed
    for (int k = 0; k < DEPTH; k++)
      send_load(fce_pkg::INDEX_BITS'(k),
                (k == 0) ? fce_pkg::TAP_BITS'(65536) : rand_tap(), 1'b0);
    // out-of-range indexes are dropped
    send_load(fce_pkg::INDEX_BITS'(DEPTH), fce_pkg::TAP_BITS'(131071), 1'b1);
    send_load('1, fce_pkg::TAP_BITS'(-131072), 1'b0);

    // single tap at reset width: identity, then saturation both ways
    send_sample(SAMPLE_BITS'(SAT_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAT_MIN), 1'b1);
    send_load('0, fce_pkg::TAP_BITS'(131071), 1'b0);
    send_sample(SAMPLE_BITS'(SAT_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAT_MIN), 1'b1);
    send_load('0, fce_pkg::TAP_BITS'(-131072), 1'b0);
    send_sample(SAMPLE_BITS'(SAT_MIN), 1'b1);

    // short frames, coefficient load inside a frame, width change mid-frame
    write_half_width(fce_pkg::CFG_BITS'(2));
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd7, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
    for (int i = 0; i < 5; i++) send_sample(rand_sample(), 1'b0);
    send_load(fce_pkg::INDEX_BITS'(2), rand_tap(), 1'b1);
    send_sample(rand_sample(), 1'b1);
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), 1'b0);
    write_half_width(fce_pkg::CFG_BITS'(31));
    for (int i = 0; i < 5; i++) send_sample(rand_sample(), i == 4);

    sent = 0;
    phase = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      case (phase)
        0:       hw = fce_pkg::CFG_BITS'(0);
        1:       hw = fce_pkg::CFG_BITS'(16);
        2:       hw = fce_pkg::CFG_BITS'(31);
        3:       hw = fce_pkg::CFG_BITS'(1);
        4:       hw = fce_pkg::CFG_BITS'(5);
        default: hw = ($urandom_range(0, 3) != 0)
                      ? fce_pkg::CFG_BITS'($urandom_range(0, 6))
                      : fce_pkg::CFG_BITS'($urandom_range(7, 31));
      endcase
      write_half_width(hw);
      heff = (hw > HALF_MAX) ? HALF_MAX : hw;
      budget = 0;
      while (budget < 40) begin
        case ($urandom_range(0, 9))
          0, 1:    frame_len = $urandom_range(1, heff + 1);
          2, 3:    frame_len = $urandom_range(1, 2 * heff + 1);
          default: frame_len = $urandom_range(2 * heff + 1, 2 * heff + 6);
        endcase
        for (int i = 0; i < frame_len; i++) begin
          if ($urandom_range(0, 11) == 0)
            send_load(fce_pkg::INDEX_BITS'($urandom_range(0, 63)), rand_tap(),
                      1'($urandom));
          send_sample(rand_sample(), i == frame_len - 1);
          budget++;
          sent++;
          if (!paused && phase == 2 && budget == 20) begin
            wait_drained();
            paused = 1'b1;
          end
        end
      end
      // leave a frame open across the next width change now and then
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < int'($urandom_range(1, 4)); i++) begin
          send_sample(rand_sample(), 1'b0);
          sent++;
        end
      end
      phase++;
    end

    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
